[src/dtnms_pkg.sv]
// ----------------------------------------------------------------------------
// dtnms_pkg: shared types and constants
// Register indexes, list entry layout, cell control bundle and FSM states.
// ----------------------------------------------------------------------------
package dtnms_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCORE_THR = 3'd0,
        REG_IOU_THR   = 3'd1,
        REG_KEEP_CNT  = 3'd2,
        REG_IMG_W     = 3'd3,
        REG_IMG_H     = 3'd4,
        REG_SCALE     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        score;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_entry;

    // Control sent down the cell row each cycle.
    typedef struct packed {
        logic ins;    // insert the new entry this cycle
        logic shift;  // shift the row toward the head (readout)
        logic clear;  // empty the row
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_CALC,
        ST_EMIT,
        ST_EMPTY
    } t_state;

endpackage

[src/dtnms_cell.sv]
// ----------------------------------------------------------------------------
// dtnms_cell: one slot of the sorted insertion list
// Holds an entry; on insert it takes the new entry, takes its upper neighbor's
// entry, or keeps its own, by score comparison; slots past list size empty.
// ----------------------------------------------------------------------------
module dtnms_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtnms_pkg::t_cell_ctl i_ctl,
    input  logic                i_en,        // slot is inside list size
    input  dtnms_pkg::t_entry   i_new,
    input  dtnms_pkg::t_entry   i_prev,      // upper neighbor entry
    input  logic                i_prev_vld,
    input  logic                i_prev_tk,   // upper neighbor or above took new
    input  dtnms_pkg::t_entry   i_next,      // lower neighbor entry
    input  logic                i_next_vld,
    output dtnms_pkg::t_entry   o_ent,
    output logic                o_vld,
    output logic                o_tk
);
    dtnms_pkg::t_entry r_ent;
    logic              r_vld;
    logic              w_beats;

    // new entry goes above this one on strictly greater score or an empty slot
    assign w_beats = !r_vld || (i_new.score > r_ent.score);
    assign o_tk    = i_prev_tk || w_beats;
    assign o_ent   = r_ent;
    assign o_vld   = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_next_vld;
            r_ent <= i_next;
        end else if (i_ctl.ins && i_en) begin
            if (i_prev_tk) begin
                r_vld <= i_prev_vld;
                r_ent <= i_prev;
            end else if (w_beats) begin
                r_vld <= 1'b1;
                r_ent <= i_new;
            end
        end else if (i_ctl.ins) begin
            r_vld <= 1'b0;
        end
    end
endmodule

[src/dtnms_scale.sv]
// ----------------------------------------------------------------------------
// dtnms_scale: coordinate rescale
// Q11.4 times Q4.12, truncate toward zero, saturate to COORD_BITS, registered.
// ----------------------------------------------------------------------------
module dtnms_scale #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic signed [15:0]           i_v,
    input  logic [15:0]                  i_scale,
    output logic signed [COORD_BITS-1:0] o_v
);
    localparam int unsigned PW = 33;
    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] w_q;
    logic signed [PW-1:0] w_max;
    logic signed [PW-1:0] w_min;
    logic signed [COORD_BITS-1:0] r_v;

    assign w_p = PW'(i_v) * $signed({1'b0, i_scale});
    assign w_q = w_p[PW-1] ? -((-w_p) >>> 16) : (w_p >>> 16);
    assign w_max = PW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    assign w_min = -w_max - PW'(1);

    always_ff @(posedge i_clk) begin
        if (w_q > w_max) begin
            r_v <= w_max[COORD_BITS-1:0];
        end else if (w_q < w_min) begin
            r_v <= w_min[COORD_BITS-1:0];
        end else begin
            r_v <= w_q[COORD_BITS-1:0];
        end
    end
    assign o_v = r_v;
endmodule

[src/detection_topk_nms_rescale.sv]
// ----------------------------------------------------------------------------
// detection_topk_nms_rescale: top-k list, greedy suppression, rescale
// Sorted insertion row of cells, then a sequenced suppression and output pass.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  cand     in   i_valid / o_stall   i_score i_box_* i_frame_end
//  result   out  o_valid / i_stall   o_found o_face_score o_out_* o_last_face
//  config   in   i_cfg_we            i_cfg_idx i_cfg_data
//
// The cell row takes each accepted candidate directly. At frame end each list
// head is checked against the earlier survivors in turn, a product phase and a
// compare phase per survivor, stopping at the first hit; the row then advances,
// and a last step closes the pass. Each survivor is then rescaled and waits on
// i_stall. Reset is synchronous, active low; the list comes up empty.
// o_stall is high from frame end until the last result is taken.
// ----------------------------------------------------------------------------
module detection_topk_nms_rescale #(
    parameter int unsigned MAX_KEEP   = 8,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_score,
    input  logic signed [15:0] i_box_x,
    input  logic signed [15:0] i_box_y,
    input  logic [14:0]        i_box_w,
    input  logic [14:0]        i_box_h,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic [15:0]        o_face_score,
    output logic [14:0]        o_out_x,
    output logic [14:0]        o_out_y,
    output logic signed [15:0] o_out_w,
    output logic signed [15:0] o_out_h,
    output logic               o_last_face
);
    localparam int unsigned NK  = (MAX_KEEP < 8) ? MAX_KEEP : 8;
    localparam int unsigned KW  = $clog2(NK + 1);
    localparam int unsigned SW  = (NK > 1) ? $clog2(NK) : 1;

    // configuration
    logic [15:0] r_score_thr, r_iou_thr, r_scale;
    logic [3:0]  r_keep;
    logic [12:0] r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_thr <= 16'd45875;
            r_iou_thr   <= 16'd26214;
            r_keep      <= 4'd5;
            r_img_w     <= 13'd640;
            r_img_h     <= 13'd640;
            r_scale     <= 16'd4096;
        end else if (i_cfg_we) begin
            case (dtnms_pkg::t_reg_idx'(i_cfg_idx))
                dtnms_pkg::REG_SCORE_THR: r_score_thr <= i_cfg_data;
                dtnms_pkg::REG_IOU_THR:   r_iou_thr   <= i_cfg_data;
                dtnms_pkg::REG_KEEP_CNT:  r_keep      <= i_cfg_data[3:0];
                dtnms_pkg::REG_IMG_W:     r_img_w     <= i_cfg_data[12:0];
                dtnms_pkg::REG_IMG_H:     r_img_h     <= i_cfg_data[12:0];
                dtnms_pkg::REG_SCALE:     r_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [KW-1:0] w_k;
    always_comb begin
        if (r_keep == 4'd0) begin
            w_k = KW'(1);
        end else if ({28'd0, r_keep} > NK) begin
            w_k = KW'(NK);
        end else begin
            w_k = KW'(r_keep);
        end
    end

    // state machine
    dtnms_pkg::t_state r_st, n_st;
    logic                w_acc;
    dtnms_pkg::t_cell_ctl w_ctl;
    dtnms_pkg::t_entry    w_new;
    dtnms_pkg::t_entry    w_ent  [NK];
    logic                 w_vld  [NK];
    logic                 w_tk   [NK];
    logic                 w_fits;

    assign w_acc = i_valid && !o_stall;
    assign w_new = '{score: i_score, x: i_box_x, y: i_box_y, w: i_box_w, h: i_box_h};
    // the new entry lands inside the list size; otherwise leave the row alone
    assign w_fits = w_tk[SW'(w_k - KW'(1))];

    // survivors stored for comparison and readout
    dtnms_pkg::t_entry r_surv [NK];
    logic [KW-1:0]     r_nsurv;
    logic [SW-1:0]     r_j;
    logic [KW-1:0]     r_left;   // entries still to process
    logic              r_hit;
    logic              r_ph;     // check phase: 0 product, 1 compare
    logic [2:0]        r_cc;
    logic              r_vout;

    for (genvar g = 0; g < NK; g++) begin : g_cell
        dtnms_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_en      (KW'(g) < w_k),
            .i_new     (w_new),
            .i_prev    ((g == 0) ? w_new : w_ent[(g == 0) ? 0 : g - 1]),
            .i_prev_vld((g == 0) ? 1'b0 : w_vld[(g == 0) ? 0 : g - 1]),
            .i_prev_tk ((g == 0) ? 1'b0 : w_tk[(g == 0) ? 0 : g - 1]),
            .i_next    (w_ent[(g == NK - 1) ? g : g + 1]),
            .i_next_vld((g == NK - 1) ? 1'b0 : w_vld[(g == NK - 1) ? g : g + 1]),
            .o_ent     (w_ent[g]),
            .o_vld     (w_vld[g]),
            .o_tk      (w_tk[g])
        );
    end

    // overlap datapath for head vs survivor r_j
    dtnms_pkg::t_entry a, b;
    assign a = w_ent[0];
    assign b = r_surv[r_j];
    logic signed [17:0] ax2, bx2, ay2, by2, x1, y1, iw, ih;
    assign ax2 = 18'(a.x) + 18'($signed({1'b0, a.w}));
    assign bx2 = 18'(b.x) + 18'($signed({1'b0, b.w}));
    assign ay2 = 18'(a.y) + 18'($signed({1'b0, a.h}));
    assign by2 = 18'(b.y) + 18'($signed({1'b0, b.h}));
    assign x1  = (a.x > b.x) ? 18'(a.x) : 18'(b.x);
    assign y1  = (a.y > b.y) ? 18'(a.y) : 18'(b.y);
    assign iw  = ((ax2 < bx2) ? ax2 : bx2) - x1;
    assign ih  = ((ay2 < by2) ? ay2 : by2) - y1;

    logic [33:0] r_inter, r_area_a, r_area_b;
    logic [31:0] w_pi;
    assign w_pi = (iw > 0 && ih > 0) ? 32'(iw[16:0]) * 32'(ih[16:0]) : 32'd0;
    always_ff @(posedge i_clk) begin
        r_inter  <= 34'(w_pi);
        r_area_a <= 34'(a.w * a.h);
        r_area_b <= 34'(b.w * b.h);
    end
    logic [34:0] w_uni;
    logic [50:0] w_lhs, w_rhs;
    assign w_uni = 35'(r_area_a) + 35'(r_area_b) - 35'(r_inter);
    assign w_lhs = 51'(r_inter) << 16;
    assign w_rhs = 51'(r_iou_thr) * 51'(w_uni);

    // rescale of the survivor being read out
    logic signed [COORD_BITS-1:0] sx, sy, sw, sh;
    dtnms_scale #(.COORD_BITS(COORD_BITS)) u_sx (.i_clk(i_clk), .i_v(b.x),
        .i_scale(r_scale), .o_v(sx));
    dtnms_scale #(.COORD_BITS(COORD_BITS)) u_sy (.i_clk(i_clk), .i_v(b.y),
        .i_scale(r_scale), .o_v(sy));
    dtnms_scale #(.COORD_BITS(COORD_BITS)) u_sw (.i_clk(i_clk),
        .i_v($signed({1'b0, b.w})), .i_scale(r_scale), .o_v(sw));
    dtnms_scale #(.COORD_BITS(COORD_BITS)) u_sh (.i_clk(i_clk),
        .i_v($signed({1'b0, b.h})), .i_scale(r_scale), .o_v(sh));

    localparam int unsigned EW = COORD_BITS + 2;
    logic signed [EW-1:0] rx, ry, rw, rh;
    always_comb begin
        rx = (sx > 0) ? EW'(sx) : '0;
        ry = (sy > 0) ? EW'(sy) : '0;
        rw = EW'(sw);
        rh = EW'(sh);
        if (!(rx + rw < $signed(EW'({1'b0, r_img_w})))) rw = EW'({1'b0, r_img_w}) - rx;
        if (!(ry + rh < $signed(EW'({1'b0, r_img_h})))) rh = EW'({1'b0, r_img_h}) - ry;
    end

    function automatic logic [14:0] sat_u(input logic signed [EW-1:0] v);
        if (v < 0) return 15'd0;
        if (v > 32767) return 15'h7FFF;
        return v[14:0];
    endfunction
    function automatic logic [15:0] sat_s(input logic signed [EW-1:0] v);
        if (v < -32768) return 16'h8000;
        if (v > 32767) return 16'h7FFF;
        return v[15:0];
    endfunction

    logic r_found, r_last;
    logic [15:0] r_fs;
    logic [14:0] r_ox, r_oy;
    logic [15:0] r_ow, r_oh;

    always_comb begin
        n_st  = r_st;
        w_ctl = '0;
        case (r_st)
            dtnms_pkg::ST_COLLECT: begin
                w_ctl.ins = w_acc && (i_score > r_score_thr) && w_fits;
                if (w_acc && i_frame_end) n_st = dtnms_pkg::ST_CHECK;
            end
            dtnms_pkg::ST_CHECK: begin
                // pass done: drop the row, survivors are held for readout
                if (r_left == '0 || !w_vld[0]) begin
                    n_st = (r_nsurv == '0) ? dtnms_pkg::ST_EMPTY : dtnms_pkg::ST_CALC;
                    w_ctl.clear = 1'b1;
                end else if (KW'(r_j) >= r_nsurv || r_hit) begin
                    w_ctl.shift = 1'b1;
                end
            end
            dtnms_pkg::ST_CALC: if (r_cc == 3'd2) n_st = dtnms_pkg::ST_EMIT;
            dtnms_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    n_st = r_last ? dtnms_pkg::ST_COLLECT : dtnms_pkg::ST_CALC;
                end
            end
            dtnms_pkg::ST_EMPTY: if (!i_stall) n_st = dtnms_pkg::ST_COLLECT;
            default: n_st = dtnms_pkg::ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dtnms_pkg::ST_COLLECT;
            r_vout <= 1'b0;
        end else begin
            r_st <= n_st;
            r_vout <= (r_st == dtnms_pkg::ST_CALC && r_cc == 3'd2) ||
                      (n_st == dtnms_pkg::ST_EMPTY) ||
                      (r_st == dtnms_pkg::ST_EMIT && i_stall);
        end
        case (r_st)
            dtnms_pkg::ST_COLLECT: begin
                r_nsurv <= '0; r_j <= '0; r_ph <= 1'b0; r_hit <= 1'b0;
                r_cc <= '0; r_left <= w_k;
            end
            dtnms_pkg::ST_CHECK: begin
                if (w_ctl.shift) begin
                    if (!r_hit) begin
                        r_surv[r_nsurv[SW-1:0]] <= a;
                        r_nsurv <= r_nsurv + KW'(1);
                    end
                    r_hit <= 1'b0; r_j <= '0; r_ph <= 1'b0;
                    r_left <= r_left - KW'(1);
                end else if (n_st == dtnms_pkg::ST_CHECK && KW'(r_j) < r_nsurv) begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (w_lhs > w_rhs) r_hit <= 1'b1;
                        else r_j <= r_j + SW'(1);
                    end
                end
                r_cc <= '0;
            end
            dtnms_pkg::ST_CALC: begin
                r_cc <= r_cc + 3'd1;
                if (r_cc == 3'd1) begin
                    r_found <= 1'b1; r_fs <= b.score;
                    r_ox <= sat_u(rx); r_oy <= sat_u(ry);
                    r_ow <= sat_s(rw); r_oh <= sat_s(rh);
                    r_last <= (KW'(r_j) == r_nsurv - KW'(1));
                end
            end
            dtnms_pkg::ST_EMIT: begin
                if (!i_stall) begin
                    r_j <= r_j + SW'(1); r_cc <= '0;
                end
            end
            default: ;
        endcase
        if (n_st == dtnms_pkg::ST_EMPTY && r_st != dtnms_pkg::ST_EMPTY) begin
            r_found <= 1'b0; r_fs <= '0; r_ox <= '0; r_oy <= '0;
            r_ow <= '0; r_oh <= '0; r_last <= 1'b1;
        end
    end

    assign o_stall      = (r_st != dtnms_pkg::ST_COLLECT);
    assign o_valid      = r_vout;
    assign o_found      = r_found;
    assign o_face_score = r_fs;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_w      = r_ow;
    assign o_out_h      = r_oh;
    assign o_last_face  = r_last;

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while taking input");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x))
        else $error("result dropped under stall");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last_face) else $error("not-found not last");
`endif
endmodule
